### rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the integer text parser: parse phases,
// radix codes, notation modes, status codes, register indexes, width codes,
// character codes, the configuration set and the per-text control state.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Parse phase of the current text.
	typedef enum logic [3:0] {
		PH_START   = 4'd0,
		PH_FIRST   = 4'd1,
		PH_ZERO    = 4'd2,
		PH_DIGITS  = 4'd3,
		PH_HEXPFX  = 4'd4,
		PH_BSUFFIX = 4'd5,
		PH_ERR     = 4'd6
	} phase_t;

	// Radix chosen for the digits of the current text.
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_OCT = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	// Notation modes held in the radix_mode register.
	localparam logic [2:0] MODE_DEC  = 3'd0;
	localparam logic [2:0] MODE_HEX  = 3'd1;
	localparam logic [2:0] MODE_OCT  = 3'd2;
	localparam logic [2:0] MODE_BIN  = 3'd3;
	localparam logic [2:0] MODE_AUTO = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;
	localparam logic [1:0] ST_WIDTH  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIX_MODE  = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
	localparam logic [1:0] REG_ALLOW_LZ    = 2'd2;
	localparam logic [1:0] REG_TARGET_W    = 2'd3;

	// Target width codes.
	localparam logic [1:0] TW_8  = 2'd0;
	localparam logic [1:0] TW_16 = 2'd1;
	localparam logic [1:0] TW_32 = 2'd2;
	localparam logic [1:0] TW_64 = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	// Configuration register set.
	typedef struct packed {
		logic [2:0] radix_mode;
		logic       signed_mode;
		logic       allow_lz;
		logic [1:0] target_width;
	} cfg_t;

	// Per-text control state (the accumulator travels alongside).
	typedef struct packed {
		phase_t     phase;
		radix_t     radix;
		logic       neg;
		logic [1:0] status;
		logic       ended;
	} text_state_t;

	localparam text_state_t TEXT_STATE_CLEAR = '{
		phase:  PH_START,
		radix:  RX_DEC,
		neg:    1'b0,
		status: ST_OK,
		ended:  1'b0
	};

endpackage

### rtl/core/integer_text_parser_unit.sv
// ----------------------------------------------------------------------------
// integer_text_parser_unit
// Multi-radix integer text parser: one text byte per beat, one result
// beat per text.
// ----------------------------------------------------------------------------
// Usage:
//   Text channel (text_valid / text_stall) carries text_byte and last_byte.
//   A text is a run of beats closed by a beat with last_byte set; a zero
//   byte ends the text early and the bytes after it are ignored.
//   The result channel (result_valid / result_stall) gives value, ok and
//   status once per text, via the input and result registers.
//   Throughput is one byte per cycle except for a stalled closing byte:
//   the parser state takes one shift-add and compare step per byte between
//   the input register and the state and result registers.
//   The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   is always ready; write it only between texts with no result pending.
//   Reset clears the parser state and loads the register defaults
//   (hex-or-decimal, unsigned, no leading zeros, 64-bit bound).
//   While the result receiver stalls, bytes that do not close a text are
//   still taken; a closing byte waits in the input register and text_stall
//   rises until the pending result is taken.
// ----------------------------------------------------------------------------
module integer_text_parser_unit #(
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Text input channel
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        last_byte,
	// Result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] value,
	output logic        ok,
	output logic [1:0]  status,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import itp_pkg::*;

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  fire;
	text_state_t           cur_st;
	logic [VALUE_BITS-1:0] cur_acc;
	text_state_t           nxt_st;
	logic [VALUE_BITS-1:0] nxt_acc;
	logic [63:0]           res_value;
	logic                  res_ok;
	logic [1:0]            res_status;
	logic                  res_valid_q;
	logic [63:0]           value_q;
	logic                  ok_q;
	logic [1:0]            status_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix_mode   <= MODE_AUTO;
			cfg_q.signed_mode  <= 1'b0;
			cfg_q.allow_lz     <= 1'b0;
			cfg_q.target_width <= TW_64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIX_MODE:  cfg_q.radix_mode   <= cfg_data;
				REG_SIGNED_MODE: cfg_q.signed_mode  <= cfg_data[0];
				REG_ALLOW_LZ:    cfg_q.allow_lz     <= cfg_data[0];
				REG_TARGET_W:    cfg_q.target_width <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// The byte in the input register proceeds unless it closes a text while
	// the previous result is still held by the receiver.
	assign fire       = valid_s1 && !(last_s1 && res_valid_q && result_stall);
	assign text_stall = valid_s1 && !fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// Parser state and its per-byte update.
	itp_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.cur       (cur_st),
		.cur_acc   (cur_acc),
		.nxt       (nxt_st),
		.nxt_acc   (nxt_acc)
	);

	// End-of-text checks and value formation.
	itp_result #(
		.VALUE_BITS(VALUE_BITS)
	) u_result (
		.st_in  (nxt_st),
		.acc    (nxt_acc),
		.cfg    (cfg_q),
		.value  (res_value),
		.ok     (res_ok),
		.status (res_status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			value_q  <= res_value;
			ok_q     <= res_ok;
			status_q <= res_status;
		end
	end

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign ok           = ok_q;
	assign status       = status_q;

	// A closing byte clears the per-text state.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> cur_st.phase == PH_START && cur_acc == '0 && !cur_st.ended)
		else $error("parser state not cleared after the closing byte");

	// The input only stalls on a closing byte behind a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1 && last_s1 && res_valid_q && result_stall)
		else $error("text channel stalled without a held result");

	// A result beat reports ok exactly for the ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ok == (status == ST_OK))
		else $error("ok flag disagrees with status");

	// A failed text gives a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ok |-> value == 64'd0)
		else $error("non-zero value on a failed text");

	// Once a text is in the error phase, it stays there until it closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_st.phase == PH_ERR && !(fire && last_s1) |=>
			cur_st.phase == PH_ERR && cur_st.status == ST_SYNTAX)
		else $error("parser left the error phase before the text closed");

endmodule

### rtl/core/itp_parse.sv
// ----------------------------------------------------------------------------
// itp_parse
// Per-text parser state and its one-byte update: phase tracking, sign,
// radix selection, syntax checks and the shift-add accumulator with
// overflow detection. The state after the current byte is presented for
// result formation; the state clears after the last byte of a text.
// ----------------------------------------------------------------------------
module itp_parse #(
	parameter int VALUE_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [7:0]              text_byte,
	input  logic                    last_byte,
	input  itp_pkg::cfg_t           cfg,
	output itp_pkg::text_state_t    cur,
	output logic [VALUE_BITS-1:0]   cur_acc,
	output itp_pkg::text_state_t    nxt,
	output logic [VALUE_BITS-1:0]   nxt_acc
);
	import itp_pkg::*;

	localparam int WIDE_BITS = VALUE_BITS + 4;

	text_state_t           state_q;
	logic [VALUE_BITS-1:0] acc_q;

	// Effective notation mode and leading-zero permission.
	logic [2:0] mode;
	logic       lz;

	assign mode = (cfg.radix_mode > MODE_AUTO) ? MODE_AUTO : cfg.radix_mode;
	assign lz   = cfg.allow_lz && !cfg.signed_mode &&
		(mode == MODE_DEC || mode == MODE_AUTO);

	// Hex digit decode of the incoming character.
	logic       is_hex;
	logic [3:0] hval;

	always_comb begin
		is_hex = 1'b0;
		hval   = text_byte[3:0];
		if (text_byte >= CH_0 && text_byte <= CH_9) begin
			is_hex = 1'b1;
		end else if ((text_byte >= CH_LA && text_byte <= CH_LF) ||
				(text_byte >= CH_UA && text_byte <= CH_UF)) begin
			is_hex = 1'b1;
			hval   = text_byte[3:0] + 4'd9;
		end
	end

	// Next-state logic for one byte.
	always_comb begin
		phase_t                ph;
		logic                  skip;
		logic                  do_acc;
		logic                  dig_ok;
		logic                  ovf;
		logic [VALUE_BITS-1:0] acc_new;
		logic [WIDE_BITS-1:0]  wide;

		nxt     = state_q;
		nxt_acc = acc_q;
		ph      = state_q.phase;
		skip    = 1'b0;
		do_acc  = 1'b0;
		dig_ok  = 1'b0;
		ovf     = 1'b0;
		acc_new = acc_q;
		wide    = '0;

		if (!state_q.ended) begin
			if (text_byte == CH_NUL) begin
				nxt.ended = 1'b1;
			end else begin
				// First character chooses the radix and may be a sign.
				if (ph == PH_START) begin
					case (mode)
						MODE_HEX: nxt.radix = RX_HEX;
						MODE_OCT: nxt.radix = RX_OCT;
						MODE_BIN: nxt.radix = RX_BIN;
						default:  nxt.radix = RX_DEC;
					endcase
					ph = PH_FIRST;
					if (cfg.signed_mode && (text_byte == CH_PLUS || text_byte == CH_MINUS)) begin
						nxt.neg = (text_byte == CH_MINUS);
						skip    = 1'b1;
					end
				end
				nxt.phase = ph;

				case (nxt.radix)
					RX_DEC:  dig_ok = is_hex && hval <= 4'd9;
					RX_OCT:  dig_ok = is_hex && hval <= 4'd7;
					RX_BIN:  dig_ok = is_hex && hval <= 4'd1;
					default: dig_ok = is_hex;
				endcase

				if (!skip) begin
					unique case (ph)
						PH_FIRST: begin
							if (mode == MODE_BIN) begin
								if (text_byte == CH_0 || text_byte == CH_1) begin
									do_acc    = 1'b1;
									nxt.phase = PH_DIGITS;
								end else begin
									nxt.status = ST_SYNTAX;
									nxt.phase  = PH_ERR;
								end
							end else if (text_byte == CH_0) begin
								nxt.phase = PH_ZERO;
							end else if ((mode == MODE_DEC || mode == MODE_AUTO) &&
									text_byte >= CH_1 && text_byte <= CH_9) begin
								do_acc    = 1'b1;
								nxt.phase = PH_DIGITS;
							end else begin
								nxt.status = ST_SYNTAX;
								nxt.phase  = PH_ERR;
							end
						end
						PH_ZERO: begin
							if ((text_byte == CH_LX || text_byte == CH_UX) &&
									(mode == MODE_HEX || mode == MODE_AUTO)) begin
								nxt.radix = RX_HEX;
								nxt.phase = PH_HEXPFX;
							end else if (mode == MODE_OCT && text_byte >= CH_0 &&
									text_byte <= CH_7) begin
								do_acc    = 1'b1;
								nxt.phase = PH_DIGITS;
							end else if (lz && text_byte >= CH_0 && text_byte <= CH_9) begin
								do_acc    = 1'b1;
								nxt.phase = PH_DIGITS;
							end else begin
								nxt.status = ST_SYNTAX;
								nxt.phase  = PH_ERR;
							end
						end
						PH_HEXPFX: begin
							if (is_hex) begin
								do_acc    = 1'b1;
								nxt.phase = PH_DIGITS;
							end else begin
								nxt.status = ST_SYNTAX;
								nxt.phase  = PH_ERR;
							end
						end
						PH_DIGITS: begin
							if (dig_ok) begin
								do_acc = 1'b1;
							end else if (nxt.radix == RX_BIN &&
									(text_byte == CH_LB || text_byte == CH_UB)) begin
								nxt.phase = PH_BSUFFIX;
							end else begin
								nxt.status = ST_SYNTAX;
								nxt.phase  = PH_ERR;
							end
						end
						PH_ERR: begin
						end
						default: begin
							nxt.status = ST_SYNTAX;
							nxt.phase  = PH_ERR;
						end
					endcase
				end

				// Shift-add step; the accumulator freezes once status is set.
				if (do_acc && state_q.status == ST_OK) begin
					case (nxt.radix)
						RX_DEC: begin
							wide = (WIDE_BITS'(acc_q) << 3) + (WIDE_BITS'(acc_q) << 1) +
								WIDE_BITS'(hval);
							ovf     = |wide[WIDE_BITS-1:VALUE_BITS];
							acc_new = wide[VALUE_BITS-1:0];
						end
						RX_HEX: begin
							ovf     = |acc_q[VALUE_BITS-1 -: 4];
							acc_new = (acc_q << 4) + VALUE_BITS'(hval);
						end
						RX_OCT: begin
							ovf     = |acc_q[VALUE_BITS-1 -: 3];
							acc_new = (acc_q << 3) + VALUE_BITS'(hval);
						end
						default: begin
							ovf     = acc_q[VALUE_BITS-1];
							acc_new = (acc_q << 1) + VALUE_BITS'(hval);
						end
					endcase
					if (ovf) begin
						nxt.status = ST_OVF;
					end else begin
						nxt_acc = acc_new;
					end
				end
			end
		end
	end

	// State register: advances on each byte and clears after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TEXT_STATE_CLEAR;
			acc_q   <= '0;
		end else if (fire) begin
			if (last_byte) begin
				state_q <= TEXT_STATE_CLEAR;
				acc_q   <= '0;
			end else begin
				state_q <= nxt;
				acc_q   <= nxt_acc;
			end
		end
	end

	assign cur     = state_q;
	assign cur_acc = acc_q;

endmodule

### rtl/core/itp_result.sv
// ----------------------------------------------------------------------------
// itp_result
// Result formation at the end of a text: checks that the text ended in an
// accepting phase, applies the sign limit and the target width bound, and
// forms the two's complement value or zero with its status.
// ----------------------------------------------------------------------------
module itp_result #(
	parameter int VALUE_BITS = 64
) (
	input  itp_pkg::text_state_t  st_in,
	input  logic [VALUE_BITS-1:0] acc,
	input  itp_pkg::cfg_t         cfg,
	output logic [63:0]           value,
	output logic                  ok,
	output logic [1:0]            status
);
	import itp_pkg::*;

	logic [63:0] mag;

	assign mag = 64'(acc);

	always_comb begin
		logic       ends_ok;
		logic       sign_bad;
		logic       above_w;
		logic       above_half;
		logic       at_half;
		logic [1:0] st;

		st       = st_in.status;
		ends_ok  = 1'b0;
		above_w  = 1'b0;
		above_half = 1'b0;
		at_half  = 1'b0;

		// The text must end in an accepting phase.
		case (st_in.phase)
			PH_ZERO:    ends_ok = (st_in.radix == RX_DEC);
			PH_DIGITS:  ends_ok = (st_in.radix != RX_BIN);
			PH_BSUFFIX: ends_ok = 1'b1;
			default:    ends_ok = 1'b0;
		endcase
		if (st != ST_SYNTAX && !ends_ok) begin
			st = ST_SYNTAX;
		end

		// Signed magnitude limit at the accumulator width.
		if (st_in.neg) begin
			sign_bad = acc[VALUE_BITS-1] && (|acc[VALUE_BITS-2:0]);
		end else begin
			sign_bad = acc[VALUE_BITS-1];
		end
		if (st == ST_OK && cfg.signed_mode && sign_bad) begin
			st = ST_OVF;
		end

		// Target width bound.
		case (cfg.target_width)
			TW_8: begin
				above_w    = |mag[63:8];
				above_half = |mag[63:7];
				at_half    = (mag == 64'h80);
			end
			TW_16: begin
				above_w    = |mag[63:16];
				above_half = |mag[63:15];
				at_half    = (mag == 64'h8000);
			end
			TW_32: begin
				above_w    = |mag[63:32];
				above_half = |mag[63:31];
				at_half    = (mag == 64'h8000_0000);
			end
			default: begin
				above_w    = 1'b0;
				above_half = 1'b0;
				at_half    = 1'b0;
			end
		endcase
		if (st == ST_OK && cfg.target_width != TW_64) begin
			if (cfg.signed_mode) begin
				if (st_in.neg ? (above_half && !at_half) : above_half) begin
					st = ST_WIDTH;
				end
			end else if (above_w) begin
				st = ST_WIDTH;
			end
		end

		status = st;
		ok     = (st == ST_OK);
		if (st != ST_OK) begin
			value = '0;
		end else if (cfg.signed_mode && st_in.neg) begin
			value = 64'd0 - mag;
		end else begin
			value = mag;
		end
	end

endmodule
